/* hdl/riot_interval_timer_sound_io_top_assert.svh */
// assertion helpers for the checker file
// the enclosing scope must provide clk and rst_n
`ifndef RIOT_INTERVAL_TIMER_SOUND_IO_TOP_ASSERT_SVH
`define RIOT_INTERVAL_TIMER_SOUND_IO_TOP_ASSERT_SVH

// same-cycle implication
`define RITS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("riot timer check failed");

// next-cycle implication
`define RITS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("riot timer check failed");

`endif

/* hdl/rits_pkg.sv */
`timescale 1ns / 1ps

package rits_pkg;

    // saturating cycle counter width and expiry latency
    localparam int ELAPSED_BITS = 20;
    localparam int EXPIRY_DELAY = 3;

    localparam int OP_BITS     = 2;
    localparam int OFFSET_BITS = 4;
    localparam int DATA_BITS   = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int LATCH_BITS  = 4;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 1;

    typedef enum logic [OP_BITS-1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_LATCH = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ATTRACT = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TONES   = 1'b1;

    // offset decode
    localparam int OFF_TIMER_BIT  = 2;
    localparam int OFF_IRQ_EN_BIT = 3;
    localparam logic [1:0] SEL_PORTA = 2'd0;
    localparam logic [1:0] SEL_PORTB = 2'd2;

    localparam logic [7:0] TIMER_TAIL = 8'hff;
    localparam logic [7:0] SAMPLE_MID = 8'h80;

    // prescaler 1, 8, 64, 1024 as a shift amount
    function automatic logic [3:0] prescale_shift(input logic [1:0] sel);
        logic [3:0] sh;
        case (sel)
            2'd0:    sh = 4'd0;
            2'd1:    sh = 4'd3;
            2'd2:    sh = 4'd6;
            default: sh = 4'd10;
        endcase
        return sh;
    endfunction

endpackage

/* hdl/rits_req_if.sv */
`timescale 1ns / 1ps

interface rits_req_if
    import rits_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [OP_BITS-1:0]     operation;
    logic [OFFSET_BITS-1:0] offset;
    logic [DATA_BITS-1:0]   write_data;

    modport source (output valid, output operation, output offset, output write_data,
                    input ready);
    modport sink   (input valid, input operation, input offset, input write_data,
                    output ready);
endinterface

/* hdl/rits_rsp_if.sv */
`timescale 1ns / 1ps

interface rits_rsp_if
    import rits_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic [DATA_BITS-1:0]          read_data;
    logic                          irq_line;
    logic                          sample_valid;
    logic signed [SAMPLE_BITS-1:0] dac_sample;

    modport source (output valid, output read_data, output irq_line, output sample_valid,
                    output dac_sample, input ready);
    modport sink   (input valid, input read_data, input irq_line, input sample_valid,
                    input dac_sample, output ready);
endinterface

/* hdl/riot_interval_timer_sound_io_top.sv */
`timescale 1ns / 1ps

// sound-board riot: interval timer, port b readback and port a dac samples
// req channel: one item per cpu cycle (tick, bus read, bus write, latch write)
// rsp channel: exactly one result per item, in order
// cfg port: cfg_we/cfg_index/cfg_data write the attract and tones switches; the user
//   must write them only while no item is in flight, the block does not enforce it
// path: a req transfer passes the input register, then the result register, to rsp
// throughput: one item per cycle while rsp is not stalled; an input register feeds a
//   single pass of timer logic that updates the state and loads the result register
// rsp stall: the result register holds, the input register still takes one
//   more item, then req.ready drops until rsp drains
// reset: timer stopped, flag and irq enable clear, counter and latch zero,
//   both switches read as one, both pipeline registers empty
module riot_interval_timer_sound_io_top
    import rits_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    rits_req_if.sink                  req,
    rits_rsp_if.source                rsp,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

    // ---------------- pipeline control ----------------
    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;
    logic advance;

    // input register payload
    op_t                    in_op_reg;
    logic [OFFSET_BITS-1:0] in_offset_reg;
    logic [DATA_BITS-1:0]   in_data_reg;

    // result register payload
    logic [DATA_BITS-1:0]          rd_reg, rd_next;
    logic                          irq_reg, irq_next;
    logic                          sv_reg, sv_next;
    logic signed [SAMPLE_BITS-1:0] smp_reg, smp_next;

    // ---------------- timer / io state ----------------
    logic                    attract_reg;
    logic                    tones_reg;
    logic [7:0]              start_reg, start_next;
    logic [1:0]              presel_reg, presel_next;
    logic                    irq_en_reg, irq_en_next;
    logic                    flag_reg, flag_next;
    logic                    running_reg, running_next;
    logic [ELAPSED_BITS-1:0] elapsed_reg, elapsed_next;
    logic [LATCH_BITS-1:0]   latch_reg, latch_next;

    // the result slot frees when empty or being taken this cycle
    assign out_free  = !out_valid_reg || rsp.ready;
    assign advance   = in_valid_reg && out_free;
    assign req.ready = !in_valid_reg || out_free;

    assign in_valid_next  = (req.valid && req.ready) || (in_valid_reg && !out_free);
    assign out_valid_next = advance || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the item on every transfer
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_op_reg     <= op_t'(req.operation);
            in_offset_reg <= req.offset;
            in_data_reg   <= req.write_data;
        end
    end

    // ---------------- single-pass item logic ----------------
    logic [3:0]              shamt;
    logic [ELAPSED_BITS-1:0] elapsed_inc;
    logic [ELAPSED_BITS-1:0] target;
    logic [ELAPSED_BITS-1:0] quot;
    logic [ELAPSED_BITS:0]   diff;
    logic                    is_timer;

    assign shamt       = prescale_shift(presel_reg);
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                      : ELAPSED_BITS'(elapsed_reg + 1'b1);
    // prescale*start + delay while waiting for expiry, then TIMER_TAIL for the tail
    assign target = flag_reg
        ? ELAPSED_BITS'(TIMER_TAIL)
        : ELAPSED_BITS'(({{(ELAPSED_BITS-8){1'b0}}, start_reg} << shamt)
                        + ELAPSED_BITS'(EXPIRY_DELAY));
    // remaining count as start minus prescaled elapsed time
    assign quot     = elapsed_reg >> shamt;
    assign diff     = {{(ELAPSED_BITS+1-8){1'b0}}, start_reg} - {1'b0, quot};
    assign is_timer = in_offset_reg[OFF_TIMER_BIT];

    always_comb
    begin
        start_next   = start_reg;
        presel_next  = presel_reg;
        irq_en_next  = irq_en_reg;
        flag_next    = flag_reg;
        running_next = running_reg;
        elapsed_next = elapsed_reg;
        latch_next   = latch_reg;
        rd_next      = '0;
        sv_next      = 1'b0;
        smp_next     = '0;

        case (in_op_reg)
            OP_TICK:
            begin
                elapsed_next = elapsed_inc;
                if (running_reg && (elapsed_inc >= target))
                begin
                    if (flag_reg)
                    begin
                        // flag never acknowledged during the tail: stop
                        running_next = 1'b0;
                    end
                    else
                    begin
                        // expiry
                        flag_next    = 1'b1;
                        elapsed_next = '0;
                    end
                end
            end
            OP_READ:
            begin
                if (!is_timer)
                begin
                    if (in_offset_reg[1:0] == SEL_PORTB)
                    begin
                        rd_next = {tones_reg, 2'b00, attract_reg, latch_reg};
                    end
                end
                else if (!in_offset_reg[0])
                begin
                    if (running_reg && flag_reg)
                    begin
                        rd_next      = 8'(TIMER_TAIL - elapsed_reg[7:0]);
                        running_next = 1'b0;
                    end
                    else if (!running_reg && diff[ELAPSED_BITS])
                    begin
                        // stopped timer never reads negative
                        rd_next = 8'd1;
                    end
                    else
                    begin
                        rd_next = diff[7:0];
                    end
                    flag_next   = 1'b0;
                    irq_en_next = in_offset_reg[OFF_IRQ_EN_BIT];
                end
            end
            OP_WRITE:
            begin
                if (!is_timer)
                begin
                    if (in_offset_reg[1:0] == SEL_PORTA)
                    begin
                        sv_next  = 1'b1;
                        smp_next = signed'({8'(SAMPLE_MID - in_data_reg), 8'h00});
                    end
                end
                else
                begin
                    // timer load and restart
                    irq_en_next  = in_offset_reg[OFF_IRQ_EN_BIT];
                    start_next   = in_data_reg;
                    presel_next  = in_offset_reg[1:0];
                    flag_next    = 1'b0;
                    running_next = 1'b1;
                    elapsed_next = '0;
                end
            end
            OP_LATCH:
            begin
                latch_next = in_data_reg[LATCH_BITS-1:0];
            end
            default:
            begin
            end
        endcase

        irq_next = flag_next && irq_en_next;
    end

    // state moves only when an item passes to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= '0;
            presel_reg  <= '0;
            irq_en_reg  <= 1'b0;
            flag_reg    <= 1'b0;
            running_reg <= 1'b0;
            elapsed_reg <= '0;
            latch_reg   <= '0;
        end
        else if (advance)
        begin
            start_reg   <= start_next;
            presel_reg  <= presel_next;
            irq_en_reg  <= irq_en_next;
            flag_reg    <= flag_next;
            running_reg <= running_next;
            elapsed_reg <= elapsed_next;
            latch_reg   <= latch_next;
        end
    end

    // board switches
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attract_reg <= 1'b1;
            tones_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ATTRACT: attract_reg <= cfg_data[0];
                CFG_TONES:   tones_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_reg  <= rd_next;
            irq_reg <= irq_next;
            sv_reg  <= sv_next;
            smp_reg <= smp_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = rd_reg;
    assign rsp.irq_line     = irq_reg;
    assign rsp.sample_valid = sv_reg;
    assign rsp.dac_sample   = smp_reg;

endmodule

/* hdl/rits_checker.sv */
`timescale 1ns / 1ps
`include "riot_interval_timer_sound_io_top_assert.svh"

module rits_checker
    import rits_pkg::*;
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [DATA_BITS-1:0]          read_data,
    input logic                          irq_line,
    input logic                          sample_valid,
    input logic signed [SAMPLE_BITS-1:0] dac_sample
);

    // whole result payload, for the hold check
    logic [DATA_BITS+SAMPLE_BITS+1:0] rsp_payload;

    assign rsp_payload = {read_data, irq_line, sample_valid, dac_sample};

    // stalled result holds
    `RITS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

    // a dac write never carries read data
    `RITS_ASSERT_IMPL(a_sample_no_read, rsp_valid && sample_valid, read_data == 8'h00)

    // no sample, no dac value
    `RITS_ASSERT_IMPL(a_dac_idle_zero, rsp_valid && !sample_valid, dac_sample == 16'sd0)

    // a fresh result follows a transfer that passed the input register, then the result register
    `RITS_ASSERT_IMPL(a_rsp_from_req, rsp_valid && !$past(rsp_valid), $past((req_valid && req_ready), 2))

endmodule

bind riot_interval_timer_sound_io_top rits_checker u_rits_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .read_data    (rsp.read_data),
    .irq_line     (rsp.irq_line),
    .sample_valid (rsp.sample_valid),
    .dac_sample   (rsp.dac_sample)
);
